// File: src/nds_pkg.sv
// ----------------------------------------------------------------------------
// nds_pkg
// Shared widths, constants and register codes for the display mode selector.
// ----------------------------------------------------------------------------
package nds_pkg;

  // Longest mode list that gets distinct positions; later modes share the last one.
  localparam int MAX_MODES = 256;
  localparam int POS_W     = (MAX_MODES > 2) ? $clog2(MAX_MODES) : 1;
  localparam int IDX_W     = (POS_W > 8) ? POS_W : 8;

  localparam int DEPTH_W = 5;
  localparam int DIM_W   = 14;
  localparam int RATE_W  = 10;
  localparam int MASK_W  = 4;
  localparam int COLOR_W = 6;
  localparam int SQ_W    = 2 * DIM_W;
  localparam int SIZE_W  = 29;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = DIM_W;

  // Bits of the care mask.
  localparam int CARE_RED   = 0;
  localparam int CARE_GREEN = 1;
  localparam int CARE_BLUE  = 2;
  localparam int CARE_RATE  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CARE_MASK   = 3'd0,
    CFG_WANT_RED    = 3'd1,
    CFG_WANT_GREEN  = 3'd2,
    CFG_WANT_BLUE   = 3'd3,
    CFG_WANT_WIDTH  = 3'd4,
    CFG_WANT_HEIGHT = 3'd5,
    CFG_WANT_RATE   = 3'd6
  } cfg_reg_t;

endpackage

// File: src/nds_if.sv
// ----------------------------------------------------------------------------
// Display mode selector channels
// Valid/ready channels for candidate modes, search results and register writes.
// ----------------------------------------------------------------------------

interface nds_in_if;
  logic                        valid;
  logic                        ready;
  logic [nds_pkg::DEPTH_W-1:0] red_bits;
  logic [nds_pkg::DEPTH_W-1:0] green_bits;
  logic [nds_pkg::DEPTH_W-1:0] blue_bits;
  logic [nds_pkg::DIM_W-1:0]   mode_width;
  logic [nds_pkg::DIM_W-1:0]   mode_height;
  logic [nds_pkg::RATE_W-1:0]  refresh_rate;
  logic                        last_mode;

  modport source (output valid, red_bits, green_bits, blue_bits, mode_width,
                  mode_height, refresh_rate, last_mode, input ready);
  modport sink   (input valid, red_bits, green_bits, blue_bits, mode_width,
                  mode_height, refresh_rate, last_mode, output ready);
endinterface

interface nds_out_if;
  logic                        valid;
  logic                        ready;
  logic [7:0]                  best_index;
  logic [nds_pkg::COLOR_W-1:0] best_color_diff;
  logic [nds_pkg::SIZE_W-1:0]  best_size_diff;
  logic [nds_pkg::RATE_W-1:0]  best_rate_diff;

  modport source (output valid, best_index, best_color_diff, best_size_diff,
                  best_rate_diff, input ready);
  modport sink   (input valid, best_index, best_color_diff, best_size_diff,
                  best_rate_diff, output ready);
endinterface

interface nds_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [nds_pkg::CFG_IDX_W-1:0]  index;
  logic [nds_pkg::CFG_DATA_W-1:0] wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

// File: src/nearest_display_mode_selector.sv
// ----------------------------------------------------------------------------
// nearest_display_mode_selector
// Finds the mode in a streamed mode list that is closest to a desired mode.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Transfer carries
//   in_ch    in   one candidate mode (depths, size, rate, last_mode)
//   out_ch   out  winner of a list (index, color/size/rate distances)
//   cfg_ch   in   one register write (index, wdata), always ready
//
// One mode is taken per cycle unless a stalled result holds it back. A mode
// passes an input register, a distance stage that holds the two squares,
// and a compare stage that adds them, updates the kept best and registers
// the result of a list. The squaring multipliers set the clock rate.
// Reset (rst_n low at a clock edge) empties the pipeline, clears the search
// and sets all configuration registers to zero. A stalled result holds only
// the last mode of the next list; modes before it keep flowing.
//
// The color distance sums absolute depth differences over cared channels and
// saturates at 63. The size distance is dw*dw + dh*dh. The rate distance is
// the absolute difference when the rate is cared, else 1023 - rate so that
// the fastest mode wins. Modes are ranked by (color, size, rate) in that
// order; on a full tie the earlier mode stays.

module nearest_display_mode_selector (
  input  logic         clk,
  input  logic         rst_n,
  nds_in_if.sink       in_ch,
  nds_out_if.source    out_ch,
  nds_cfg_if.sink      cfg_ch
);

  // Configuration registers.
  logic [nds_pkg::MASK_W-1:0]  care_mask_r;
  logic [nds_pkg::DEPTH_W-1:0] want_red_r;
  logic [nds_pkg::DEPTH_W-1:0] want_green_r;
  logic [nds_pkg::DEPTH_W-1:0] want_blue_r;
  logic [nds_pkg::DIM_W-1:0]   want_width_r;
  logic [nds_pkg::DIM_W-1:0]   want_height_r;
  logic [nds_pkg::RATE_W-1:0]  want_rate_r;

  // Input register.
  logic                        s1_valid_r;
  logic [nds_pkg::DEPTH_W-1:0] s1_red_r;
  logic [nds_pkg::DEPTH_W-1:0] s1_green_r;
  logic [nds_pkg::DEPTH_W-1:0] s1_blue_r;
  logic [nds_pkg::DIM_W-1:0]   s1_width_r;
  logic [nds_pkg::DIM_W-1:0]   s1_height_r;
  logic [nds_pkg::RATE_W-1:0]  s1_rate_r;
  logic                        s1_last_r;

  // Distance stage.
  logic                        s2_valid_r;
  logic [nds_pkg::COLOR_W-1:0] s2_color_r;
  logic [nds_pkg::SQ_W-1:0]    s2_wsq_r;
  logic [nds_pkg::SQ_W-1:0]    s2_hsq_r;
  logic [nds_pkg::RATE_W-1:0]  s2_rate_r;
  logic                        s2_last_r;

  // Search state.
  logic                        have_best_r;
  logic [nds_pkg::POS_W-1:0]   pos_r;
  logic [nds_pkg::POS_W-1:0]   kept_index_r;
  logic [nds_pkg::COLOR_W-1:0] kept_color_r;
  logic [nds_pkg::SIZE_W-1:0]  kept_size_r;
  logic [nds_pkg::RATE_W-1:0]  kept_rate_r;

  // Result register.
  logic                        out_valid_r;
  logic [7:0]                  out_index_r;
  logic [nds_pkg::COLOR_W-1:0] out_color_r;
  logic [nds_pkg::SIZE_W-1:0]  out_size_r;
  logic [nds_pkg::RATE_W-1:0]  out_rate_r;

  // Handshake and datapath signals.
  logic                        in_fire;
  logic                        out_free;
  logic                        s2_load;
  logic                        s3_fire;

  logic [nds_pkg::DEPTH_W-1:0] dr;
  logic [nds_pkg::DEPTH_W-1:0] dg;
  logic [nds_pkg::DEPTH_W-1:0] db;
  logic [nds_pkg::COLOR_W:0]   color_sum;
  logic [nds_pkg::COLOR_W-1:0] color_nxt;
  logic [nds_pkg::DIM_W-1:0]   dw;
  logic [nds_pkg::DIM_W-1:0]   dh;
  logic [nds_pkg::SQ_W-1:0]    wsq_nxt;
  logic [nds_pkg::SQ_W-1:0]    hsq_nxt;
  logic [nds_pkg::RATE_W-1:0]  rate_nxt;

  logic [nds_pkg::SIZE_W-1:0]  size_cur;
  logic                        color_eq;
  logic                        size_eq;
  logic                        take;
  logic [nds_pkg::POS_W-1:0]   kept_index_nxt;
  logic [nds_pkg::COLOR_W-1:0] kept_color_nxt;
  logic [nds_pkg::SIZE_W-1:0]  kept_size_nxt;
  logic [nds_pkg::RATE_W-1:0]  kept_rate_nxt;
  logic [nds_pkg::IDX_W-1:0]   index_ext;

  // --------------------------------------------------------------------------
  // Flow control. Only a last mode needs room in the result register, so the
  // compare stage stalls only for that case and every stage before it drains
  // into the next as soon as that one moves on.
  // --------------------------------------------------------------------------
  always_comb begin
    out_free    = !out_valid_r || out_ch.ready;
    s3_fire     = s2_valid_r && (!s2_last_r || out_free);
    s2_load     = s1_valid_r && (!s2_valid_r || s3_fire);
    in_ch.ready = !s1_valid_r || s2_load;
    in_fire     = in_ch.valid && in_ch.ready;
  end

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      care_mask_r   <= '0;
      want_red_r    <= '0;
      want_green_r  <= '0;
      want_blue_r   <= '0;
      want_width_r  <= '0;
      want_height_r <= '0;
      want_rate_r   <= '0;
    end else if (cfg_ch.valid) begin
      case (nds_pkg::cfg_reg_t'(cfg_ch.index))
        nds_pkg::CFG_CARE_MASK:   care_mask_r   <= cfg_ch.wdata[nds_pkg::MASK_W-1:0];
        nds_pkg::CFG_WANT_RED:    want_red_r    <= cfg_ch.wdata[nds_pkg::DEPTH_W-1:0];
        nds_pkg::CFG_WANT_GREEN:  want_green_r  <= cfg_ch.wdata[nds_pkg::DEPTH_W-1:0];
        nds_pkg::CFG_WANT_BLUE:   want_blue_r   <= cfg_ch.wdata[nds_pkg::DEPTH_W-1:0];
        nds_pkg::CFG_WANT_WIDTH:  want_width_r  <= cfg_ch.wdata[nds_pkg::DIM_W-1:0];
        nds_pkg::CFG_WANT_HEIGHT: want_height_r <= cfg_ch.wdata[nds_pkg::DIM_W-1:0];
        nds_pkg::CFG_WANT_RATE:   want_rate_r   <= cfg_ch.wdata[nds_pkg::RATE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input register.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s2_load) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_red_r    <= in_ch.red_bits;
      s1_green_r  <= in_ch.green_bits;
      s1_blue_r   <= in_ch.blue_bits;
      s1_width_r  <= in_ch.mode_width;
      s1_height_r <= in_ch.mode_height;
      s1_rate_r   <= in_ch.refresh_rate;
      s1_last_r   <= in_ch.last_mode;
    end
  end

  // --------------------------------------------------------------------------
  // Distances. Channels that are not cared contribute zero to the color sum.
  // --------------------------------------------------------------------------
  always_comb begin
    dr = '0;
    dg = '0;
    db = '0;
    if (care_mask_r[nds_pkg::CARE_RED]) begin
      dr = (s1_red_r >= want_red_r) ? s1_red_r - want_red_r : want_red_r - s1_red_r;
    end
    if (care_mask_r[nds_pkg::CARE_GREEN]) begin
      dg = (s1_green_r >= want_green_r) ? s1_green_r - want_green_r
                                        : want_green_r - s1_green_r;
    end
    if (care_mask_r[nds_pkg::CARE_BLUE]) begin
      db = (s1_blue_r >= want_blue_r) ? s1_blue_r - want_blue_r : want_blue_r - s1_blue_r;
    end
    color_sum = (nds_pkg::COLOR_W+1)'(dr) + (nds_pkg::COLOR_W+1)'(dg)
              + (nds_pkg::COLOR_W+1)'(db);
    color_nxt = color_sum[nds_pkg::COLOR_W] ? {nds_pkg::COLOR_W{1'b1}}
                                            : color_sum[nds_pkg::COLOR_W-1:0];

    dw = (s1_width_r >= want_width_r) ? s1_width_r - want_width_r
                                      : want_width_r - s1_width_r;
    dh = (s1_height_r >= want_height_r) ? s1_height_r - want_height_r
                                        : want_height_r - s1_height_r;
    wsq_nxt = nds_pkg::SQ_W'(dw) * nds_pkg::SQ_W'(dw);
    hsq_nxt = nds_pkg::SQ_W'(dh) * nds_pkg::SQ_W'(dh);

    if (care_mask_r[nds_pkg::CARE_RATE]) begin
      rate_nxt = (s1_rate_r >= want_rate_r) ? s1_rate_r - want_rate_r
                                            : want_rate_r - s1_rate_r;
    end else begin
      // All-ones minus the rate: the fastest mode gets the smallest distance.
      rate_nxt = ~s1_rate_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_load) begin
      s2_valid_r <= 1'b1;
    end else if (s3_fire) begin
      s2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_color_r <= color_nxt;
      s2_wsq_r   <= wsq_nxt;
      s2_hsq_r   <= hsq_nxt;
      s2_rate_r  <= rate_nxt;
      s2_last_r  <= s1_last_r;
    end
  end

  // --------------------------------------------------------------------------
  // Compare stage. The first mode of a list is always taken; after that a
  // mode replaces the kept one only if it is strictly smaller in the
  // (color, size, rate) order.
  // --------------------------------------------------------------------------
  always_comb begin
    size_cur = nds_pkg::SIZE_W'(s2_wsq_r) + nds_pkg::SIZE_W'(s2_hsq_r);
    color_eq = (s2_color_r == kept_color_r);
    size_eq  = (size_cur == kept_size_r);
    take     = !have_best_r
            || (s2_color_r < kept_color_r)
            || (color_eq && (size_cur < kept_size_r))
            || (color_eq && size_eq && (s2_rate_r < kept_rate_r));

    kept_index_nxt = take ? pos_r      : kept_index_r;
    kept_color_nxt = take ? s2_color_r : kept_color_r;
    kept_size_nxt  = take ? size_cur   : kept_size_r;
    kept_rate_nxt  = take ? s2_rate_r  : kept_rate_r;
    index_ext      = nds_pkg::IDX_W'(kept_index_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_best_r <= 1'b0;
      pos_r       <= '0;
    end else if (s3_fire) begin
      if (s2_last_r) begin
        have_best_r <= 1'b0;
        pos_r       <= '0;
      end else begin
        have_best_r <= 1'b1;
        // The position saturates, so modes beyond the limit share the last index.
        if (pos_r != nds_pkg::POS_W'(nds_pkg::MAX_MODES - 1)) begin
          pos_r <= pos_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3_fire) begin
      kept_index_r <= kept_index_nxt;
      kept_color_r <= kept_color_nxt;
      kept_size_r  <= kept_size_nxt;
      kept_rate_r  <= kept_rate_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Result register.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s3_fire && s2_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_fire && s2_last_r) begin
      out_index_r <= index_ext[7:0];
      out_color_r <= kept_color_nxt;
      out_size_r  <= kept_size_nxt;
      out_rate_r  <= kept_rate_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.best_index      = out_index_r;
  assign out_ch.best_color_diff = out_color_r;
  assign out_ch.best_size_diff  = out_size_r;
  assign out_ch.best_rate_diff  = out_rate_r;

endmodule

// File: dv/tb_nearest_display_mode_selector.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nearest_display_mode_selector
// Self-checking bench for the nearest display mode selector. Candidate mode
// lists are streamed against several desired modes. A software scorer in the
// bench ranks every accepted mode and queues the winner of each list. Each
// result transfer is compared field by field with the oldest queued winner.
// ----------------------------------------------------------------------------

module tb_nearest_display_mode_selector;

  // Time left for the pipeline to settle before the configuration is touched
  // or the run ends.
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned CYCLE_LIMIT   = 400000;

  localparam int unsigned DEPTH_MAX = (1 << nds_pkg::DEPTH_W) - 1;
  localparam int unsigned DIM_MAX   = (1 << nds_pkg::DIM_W) - 1;
  localparam int unsigned RATE_MAX  = (1 << nds_pkg::RATE_W) - 1;
  localparam int unsigned COLOR_MAX = (1 << nds_pkg::COLOR_W) - 1;

  // One candidate mode as it travels on the input channel.
  typedef struct packed {
    logic [nds_pkg::DEPTH_W-1:0] red;
    logic [nds_pkg::DEPTH_W-1:0] green;
    logic [nds_pkg::DEPTH_W-1:0] blue;
    logic [nds_pkg::DIM_W-1:0]   width;
    logic [nds_pkg::DIM_W-1:0]   height;
    logic [nds_pkg::RATE_W-1:0]  rate;
    logic                        last;
  } mode_t;

  // The desired mode, i.e. the contents of the register file.
  typedef struct packed {
    logic [nds_pkg::MASK_W-1:0]  care;
    logic [nds_pkg::DEPTH_W-1:0] red;
    logic [nds_pkg::DEPTH_W-1:0] green;
    logic [nds_pkg::DEPTH_W-1:0] blue;
    logic [nds_pkg::DIM_W-1:0]   width;
    logic [nds_pkg::DIM_W-1:0]   height;
    logic [nds_pkg::RATE_W-1:0]  rate;
  } desired_t;

  // The winner of one list, as it is expected on the result channel.
  typedef struct packed {
    logic [7:0]                  index;
    logic [nds_pkg::COLOR_W-1:0] color;
    logic [nds_pkg::SIZE_W-1:0]  size_diff;
    logic [nds_pkg::RATE_W-1:0]  rate;
  } winner_t;

  logic clk;
  logic rst_n;

  nds_in_if  in_ch ();
  nds_out_if out_ch ();
  nds_cfg_if cfg_ch ();

  nearest_display_mode_selector dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Scorer state: the register file as the bench believes it to be, and the
  // running best of the list that is currently being streamed.
  desired_t    desired;
  logic        search_open;
  int unsigned list_pos;
  int unsigned best_pos;
  int unsigned best_color;
  int unsigned best_size;
  int unsigned best_rate;
  winner_t     expected_winners[$];

  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned mismatches;
  int unsigned cycle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Scorer
  // ---------------------------------------------------------------------------

  function automatic int unsigned gap(int unsigned a, int unsigned b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // Ranks one accepted mode against the running best and, when the mode closes
  // its list, queues the winner and opens a fresh search.
  function automatic void rank_mode(mode_t m);
    int unsigned color;
    int unsigned dw;
    int unsigned dh;
    int unsigned size_d;
    int unsigned rate_d;
    winner_t     w;
    color = 0;
    if (desired.care[nds_pkg::CARE_RED])   color += gap(m.red, desired.red);
    if (desired.care[nds_pkg::CARE_GREEN]) color += gap(m.green, desired.green);
    if (desired.care[nds_pkg::CARE_BLUE])  color += gap(m.blue, desired.blue);
    if (color > COLOR_MAX) color = COLOR_MAX;
    dw     = gap(m.width, desired.width);
    dh     = gap(m.height, desired.height);
    size_d = dw * dw + dh * dh;
    // Without a rate preference the fastest mode is the closest one.
    rate_d = desired.care[nds_pkg::CARE_RATE] ? gap(m.rate, desired.rate)
                                              : RATE_MAX - m.rate;
    // Strictly better only: on a full tie the earlier mode is kept.
    if (!search_open || color < best_color ||
        (color == best_color && size_d < best_size) ||
        (color == best_color && size_d == best_size && rate_d < best_rate)) begin
      search_open = 1'b1;
      best_pos    = list_pos;
      best_color  = color;
      best_size   = size_d;
      best_rate   = rate_d;
    end
    // Positions stop counting at the last slot; later modes share it.
    if (list_pos < nds_pkg::MAX_MODES - 1) list_pos++;
    if (m.last) begin
      w.index     = 8'(best_pos);
      w.color     = nds_pkg::COLOR_W'(best_color);
      w.size_diff = nds_pkg::SIZE_W'(best_size);
      w.rate      = nds_pkg::RATE_W'(best_rate);
      expected_winners.push_back(w);
      search_open = 1'b0;
      list_pos    = 0;
      best_pos    = 0;
      best_color  = 0;
      best_size   = 0;
      best_rate   = 0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Presents one mode and returns at the edge of its transfer. Valid stays
  // high afterwards so that back-to-back modes need no second assignment in
  // the same step; gaps and the drain task lower it.
  task automatic send_mode(mode_t m);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.red_bits     <= m.red;
    in_ch.green_bits   <= m.green;
    in_ch.blue_bits    <= m.blue;
    in_ch.mode_width   <= m.width;
    in_ch.mode_height  <= m.height;
    in_ch.refresh_rate <= m.rate;
    in_ch.last_mode    <= m.last;
    do @(posedge clk); while (!in_ch.ready);
    rank_mode(m);
  endtask

  // Holds the sender off until every queued winner has come out, then lets
  // the pipeline settle, since modes without a result may still be inside.
  task automatic wait_for_winners();
    in_ch.valid <= 1'b0;
    while (expected_winners.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(nds_pkg::cfg_reg_t idx, int unsigned value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.wdata <= nds_pkg::CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      nds_pkg::CFG_CARE_MASK:   desired.care   = nds_pkg::MASK_W'(value);
      nds_pkg::CFG_WANT_RED:    desired.red    = nds_pkg::DEPTH_W'(value);
      nds_pkg::CFG_WANT_GREEN:  desired.green  = nds_pkg::DEPTH_W'(value);
      nds_pkg::CFG_WANT_BLUE:   desired.blue   = nds_pkg::DEPTH_W'(value);
      nds_pkg::CFG_WANT_WIDTH:  desired.width  = nds_pkg::DIM_W'(value);
      nds_pkg::CFG_WANT_HEIGHT: desired.height = nds_pkg::DIM_W'(value);
      nds_pkg::CFG_WANT_RATE:   desired.rate   = nds_pkg::RATE_W'(value);
      default: ;
    endcase
  endtask

  // Rewrites the whole register file, only ever with the block idle.
  task automatic program_desired(desired_t d);
    wait_for_winners();
    write_reg(nds_pkg::CFG_CARE_MASK, d.care);
    write_reg(nds_pkg::CFG_WANT_RED, d.red);
    write_reg(nds_pkg::CFG_WANT_GREEN, d.green);
    write_reg(nds_pkg::CFG_WANT_BLUE, d.blue);
    write_reg(nds_pkg::CFG_WANT_WIDTH, d.width);
    write_reg(nds_pkg::CFG_WANT_HEIGHT, d.height);
    write_reg(nds_pkg::CFG_WANT_RATE, d.rate);
    cfg_ch.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Random content
  // ---------------------------------------------------------------------------

  // Field values cluster around the desired value so that close contests and
  // exact ties are common, with extremes and the full range mixed in.
  function automatic int unsigned pick_value(int unsigned target, int unsigned top);
    int s;
    case ($urandom_range(4))
      0: return target;
      1: return $urandom_range(1) ? top : 0;
      2: begin
        s = int'(target) + int'($urandom_range(6)) - 3;
        return (s < 0) ? 0 : ((s > int'(top)) ? top : s);
      end
      default: return $urandom_range(top);
    endcase
  endfunction

  function automatic mode_t random_mode();
    mode_t m;
    m.red    = nds_pkg::DEPTH_W'(pick_value(desired.red, DEPTH_MAX));
    m.green  = nds_pkg::DEPTH_W'(pick_value(desired.green, DEPTH_MAX));
    m.blue   = nds_pkg::DEPTH_W'(pick_value(desired.blue, DEPTH_MAX));
    m.width  = nds_pkg::DIM_W'(pick_value(desired.width, DIM_MAX));
    m.height = nds_pkg::DIM_W'(pick_value(desired.height, DIM_MAX));
    m.rate   = nds_pkg::RATE_W'(pick_value(desired.rate, RATE_MAX));
    m.last   = 1'b0;
    return m;
  endfunction

  function automatic desired_t random_setting();
    desired_t d;
    d.care   = nds_pkg::MASK_W'($urandom_range(15));
    d.red    = nds_pkg::DEPTH_W'($urandom_range(DEPTH_MAX));
    d.green  = nds_pkg::DEPTH_W'($urandom_range(DEPTH_MAX));
    d.blue   = nds_pkg::DEPTH_W'($urandom_range(DEPTH_MAX));
    d.width  = nds_pkg::DIM_W'($urandom_range(DIM_MAX));
    d.height = nds_pkg::DIM_W'($urandom_range(DIM_MAX));
    d.rate   = nds_pkg::RATE_W'($urandom_range(RATE_MAX));
    return d;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Registers still at their reset value: nothing is cared, so only size and
  // the fastest rate decide. Includes a one-mode list.
  task automatic test_reset_values();
    send_mode('{5, 6, 7, 100, 50, 60, 1});
    send_mode('{0, 0, 0, 10, 10, 500, 0});
    send_mode('{1, 1, 1, 0, 0, 200, 0});
    send_mode('{2, 2, 2, 0, 0, 900, 1});
    wait_for_winners();
  endtask

  // Field extremes against extreme desired modes, the largest size distance,
  // depths above sixteen and a color distance that saturates.
  task automatic test_field_extremes();
    program_desired('{4'hF, 0, DEPTH_MAX, 16, DIM_MAX, 0, RATE_MAX});
    send_mode('{0, 0, 0, 0, 0, 0, 0});
    send_mode('{DEPTH_MAX, DEPTH_MAX, DEPTH_MAX, DIM_MAX, DIM_MAX, RATE_MAX, 0});
    send_mode('{DEPTH_MAX, 0, 0, 0, DIM_MAX, 0, 0});
    send_mode('{16, DEPTH_MAX, 0, DIM_MAX, 0, RATE_MAX, 1});
    program_desired('{4'h0, DEPTH_MAX, DEPTH_MAX, DEPTH_MAX, 0, DIM_MAX, 0});
    send_mode('{0, 0, 0, 0, 0, 0, 0});
    send_mode('{DEPTH_MAX, DEPTH_MAX, DEPTH_MAX, DIM_MAX, DIM_MAX, RATE_MAX, 0});
    send_mode('{0, 0, 0, 0, DIM_MAX, RATE_MAX, 1});
    // Both modes saturate the color distance and then tie completely.
    program_desired('{4'h7, 0, 0, 0, 0, 0, 0});
    send_mode('{DEPTH_MAX, DEPTH_MAX, DEPTH_MAX, 0, 0, 0, 0});
    send_mode('{DEPTH_MAX, DEPTH_MAX, 30, 0, 0, 0, 1});
    wait_for_winners();
  endtask

  // Color outranks size, size outranks rate, and a full tie keeps the
  // earlier mode.
  task automatic test_ranking_order();
    program_desired('{4'hF, 8, 8, 8, 640, 480, 60});
    send_mode('{8, 8, 9, 640, 480, 60, 0});
    send_mode('{8, 8, 8, 1000, 1000, 60, 0});
    send_mode('{8, 8, 8, 641, 480, 0, 0});
    send_mode('{8, 8, 8, 640, 481, 61, 0});
    send_mode('{8, 8, 8, 640, 481, 59, 0});
    send_mode('{8, 8, 8, 640, 481, 61, 1});
    send_mode('{8, 8, 8, 640, 480, 60, 1});
    wait_for_winners();
  endtask

  // Mostly short lists with random content; a mode is sometimes repeated to
  // force ties. Optionally the sender pauses halfway for a full drain.
  task automatic run_random_lists(int unsigned item_goal, bit mid_pause);
    mode_t       m;
    int unsigned sent;
    int unsigned len;
    sent = 0;
    m    = '0;
    while (sent < item_goal) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      for (int unsigned i = 0; i < len; i++) begin
        if (i == 0 || $urandom_range(5) != 0) m = random_mode();
        m.last = (i == len - 1);
        send_mode(m);
      end
      sent += len;
      if (mid_pause && sent >= item_goal / 2) begin
        wait_for_winners();
        mid_pause = 1'b0;
      end
    end
  endtask

  task automatic test_random_phase(int unsigned idle, int unsigned stall);
    idle_pct  = idle;
    stall_pct = stall;
    for (int unsigned k = 0; k < 2; k++) begin
      program_desired(random_setting());
      run_random_lists(175, k == 1);
    end
  endtask

  // Lists longer than the position counter. Exact matches are planted in a
  // tail that starts around the saturation point, so the winner often sits
  // in the shared last slot.
  task automatic test_long_lists();
    mode_t       m;
    int unsigned len;
    int unsigned tail;
    for (int unsigned k = 0; k < 2; k++) begin
      program_desired(random_setting());
      len  = $urandom_range(nds_pkg::MAX_MODES + 1, nds_pkg::MAX_MODES + 34);
      tail = $urandom_range(nds_pkg::MAX_MODES - 6, nds_pkg::MAX_MODES + 14);
      for (int unsigned i = 0; i < len; i++) begin
        m = random_mode();
        if (i >= tail && $urandom_range(1) == 1) begin
          m = '{desired.red, desired.green, desired.blue, desired.width,
                desired.height,
                desired.care[nds_pkg::CARE_RATE] ? desired.rate : RATE_MAX, 1'b0};
        end
        m.last = (i == len - 1);
        send_mode(m);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what);
    $display("MISMATCH @%0t: %s", $time, what);
    mismatches++;
  endtask

  // The receiver is ready at random according to the current stall rate.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Values are sampled as they stood just before the edge, which is when the
  // transfer takes place.
  always @(posedge clk) begin : check_results
    winner_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_winners.size() == 0) begin
        report_mismatch("result transfer while no list was pending");
      end else begin
        w = expected_winners.pop_front();
        if (out_ch.best_index !== w.index)
          report_mismatch($sformatf("best_index %0d, expected %0d",
                                    out_ch.best_index, w.index));
        if (out_ch.best_color_diff !== w.color)
          report_mismatch($sformatf("best_color_diff %0d, expected %0d",
                                    out_ch.best_color_diff, w.color));
        if (out_ch.best_size_diff !== w.size_diff)
          report_mismatch($sformatf("best_size_diff %0d, expected %0d",
                                    out_ch.best_size_diff, w.size_diff));
        if (out_ch.best_rate_diff !== w.rate)
          report_mismatch($sformatf("best_rate_diff %0d, expected %0d",
                                    out_ch.best_rate_diff, w.rate));
      end
    end
  end

  // A hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("nearest_display_mode_selector regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n              = 1'b0;
    idle_pct           = 0;
    stall_pct          = 0;
    in_ch.valid        = 1'b0;
    in_ch.red_bits     = '0;
    in_ch.green_bits   = '0;
    in_ch.blue_bits    = '0;
    in_ch.mode_width   = '0;
    in_ch.mode_height  = '0;
    in_ch.refresh_rate = '0;
    in_ch.last_mode    = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = nds_pkg::CFG_CARE_MASK;
    cfg_ch.wdata       = '0;
    desired            = '0;
    search_open        = 1'b0;
    list_pos           = 0;
    best_pos           = 0;
    best_color         = 0;
    best_size          = 0;
    best_rate          = 0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, with both sides always willing.
    test_reset_values();
    test_field_extremes();
    test_ranking_order();

    // Random part, one idling pattern per phase.
    test_random_phase(0, 0);
    test_random_phase(62, 0);
    test_random_phase(0, 62);
    test_random_phase(19, 19);
    test_long_lists();

    wait_for_winners();
    if (mismatches == 0) begin
      $display("nearest_display_mode_selector regression: pass");
    end else begin
      $display("nearest_display_mode_selector regression: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/nds_pkg.sv
src/nds_if.sv
src/nearest_display_mode_selector.sv
dv/tb_nearest_display_mode_selector.sv
